>>> hw/rtl/fpga_parallel_config_loader_top_macros.svh
// Assertion helpers for the configuration loader.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef FPGA_PARALLEL_CONFIG_LOADER_TOP_MACROS_SVH
`define FPGA_PARALLEL_CONFIG_LOADER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPCL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fpcl assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FPCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fpcl assertion failed");

`endif

>>> hw/rtl/fpcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpcl_pkg;

	localparam int POLL_W = 20;
	localparam int PULSE_W = 10;
	localparam int BYTE_W = 8;
	localparam int PIN_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 20;

	// Bit positions inside the pin level vector.
	localparam int PIN_PROG = 0;
	localparam int PIN_CLOCK = 1;
	localparam int PIN_SELECT = 2;
	localparam int PIN_WRITE = 3;

	localparam logic [PIN_W-1:0] PINS_RESET = 4'hF;
	localparam logic [PIN_W-1:0] PINS_START = 4'hE;
	localparam logic [BYTE_W-1:0] BUS_IDLE = 8'hFF;
	localparam logic [POLL_W-1:0] POLL_ONE = 20'd1;

	localparam logic [POLL_W-1:0] INIT_LOW_RESET = 20'd100;
	localparam logic [POLL_W-1:0] INIT_HIGH_RESET = 20'd1000000;
	localparam logic [PULSE_W-1:0] DONE_RESET = 10'd100;
	localparam logic [PULSE_W-1:0] TRAIL_RESET = 10'd100;

	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_RESET_LOW = 4'd1,
		PH_LOADING = 4'd2,
		PH_WAIT_DONE = 4'd3,
		PH_TRAILING = 4'd4,
		PH_CONFIGURED = 4'd5,
		PH_RESET_TIMEOUT = 4'd6,
		PH_CRC_ERROR = 4'd7,
		PH_DONE_TIMEOUT = 4'd8,
		PH_RESET_HIGH = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_START = 2'd1,
		CMD_BYTE = 2'd2,
		CMD_END = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INIT_LOW = 2'd0,
		REG_INIT_HIGH = 2'd1,
		REG_DONE = 2'd2,
		REG_TRAIL = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] stream_byte;
		logic init_pin;
		logic done_pin;
	} req_t;

	typedef struct packed {
		logic prog_pin;
		logic clock_pin;
		logic select_pin;
		logic write_pin;
		logic [7:0] bus_data;
		logic [3:0] status;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic [POLL_W-1:0] init_low_limit;
		logic [POLL_W-1:0] init_high_limit;
		logic [PULSE_W-1:0] done_limit;
		logic [PULSE_W-1:0] trailing_pulses;
	} cfg_t;

	typedef struct packed {
		phase_t phase;
		logic [POLL_W-1:0] poll;
		logic [PIN_W-1:0] pins;
		logic [BYTE_W-1:0] bus;
	} state_t;

	// Mirror the byte so that stream bit 0 lands on bus bit 7.
	function automatic logic [BYTE_W-1:0] flip_byte(input logic [BYTE_W-1:0] v);
		logic [BYTE_W-1:0] r;
		for (int i = 0; i < BYTE_W; i++) begin
			r[i] = v[BYTE_W-1-i];
		end
		return r;
	endfunction

	// Build a result item from the current port state.
	function automatic rsp_t make_rsp(input state_t s, input logic is_last);
		rsp_t r;
		r.prog_pin = s.pins[PIN_PROG];
		r.clock_pin = s.pins[PIN_CLOCK];
		r.select_pin = s.pins[PIN_SELECT];
		r.write_pin = s.pins[PIN_WRITE];
		r.bus_data = s.bus;
		r.status = (s.phase == PH_RESET_HIGH) ? 4'(PH_RESET_LOW) : 4'(s.phase);
		r.last = is_last;
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fpcl_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module fpcl_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic [fpcl_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [fpcl_pkg::CFG_DATA_W-1:0] cfg_data,
	output fpcl_pkg::cfg_t cfg
);

	fpcl_pkg::cfg_t cfg_q;

	// Register file for the timeout and pulse limits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.init_low_limit <= fpcl_pkg::INIT_LOW_RESET;
			cfg_q.init_high_limit <= fpcl_pkg::INIT_HIGH_RESET;
			cfg_q.done_limit <= fpcl_pkg::DONE_RESET;
			cfg_q.trailing_pulses <= fpcl_pkg::TRAIL_RESET;
		end else if (cfg_write) begin
			case (fpcl_pkg::reg_idx_t'(cfg_index))
				fpcl_pkg::REG_INIT_LOW: begin
					cfg_q.init_low_limit <= cfg_data[fpcl_pkg::POLL_W-1:0];
				end
				fpcl_pkg::REG_INIT_HIGH: begin
					cfg_q.init_high_limit <= cfg_data[fpcl_pkg::POLL_W-1:0];
				end
				fpcl_pkg::REG_DONE: begin
					cfg_q.done_limit <= cfg_data[fpcl_pkg::PULSE_W-1:0];
				end
				fpcl_pkg::REG_TRAIL: begin
					cfg_q.trailing_pulses <= cfg_data[fpcl_pkg::PULSE_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> hw/rtl/fpcl_step.sv
`timescale 1ns / 1ps
`default_nettype none

module fpcl_step (
	input wire fpcl_pkg::state_t cur,
	input wire fpcl_pkg::req_t req,
	input wire fpcl_pkg::cfg_t cfg,
	output fpcl_pkg::state_t nxt,
	output fpcl_pkg::rsp_t first,
	output fpcl_pkg::rsp_t second,
	output logic two
);

	fpcl_pkg::state_t low_st;
	fpcl_pkg::rsp_t mid;
	logic [fpcl_pkg::POLL_W-1:0] poll_inc;
	logic [fpcl_pkg::POLL_W-1:0] wait_limit;
	logic [fpcl_pkg::POLL_W-1:0] done_lim;
	logic [fpcl_pkg::POLL_W-1:0] trail_lim;
	logic low_wait;
	logic finished;

	// One command against the current port state; a byte or a clock pulse gives two items.
	always_comb begin
		nxt = cur;
		two = 1'b0;
		low_st = cur;
		low_st.pins[fpcl_pkg::PIN_CLOCK] = 1'b0;
		poll_inc = cur.poll + fpcl_pkg::POLL_ONE;
		low_wait = (cur.phase == fpcl_pkg::PH_RESET_LOW);
		wait_limit = low_wait ? cfg.init_low_limit : cfg.init_high_limit;
		done_lim = fpcl_pkg::POLL_W'(cfg.done_limit);
		trail_lim = fpcl_pkg::POLL_W'(cfg.trailing_pulses);
		finished = (cur.phase == fpcl_pkg::PH_CONFIGURED) ||
			(cur.phase == fpcl_pkg::PH_RESET_TIMEOUT) ||
			(cur.phase == fpcl_pkg::PH_CRC_ERROR) ||
			(cur.phase == fpcl_pkg::PH_DONE_TIMEOUT);

		case (fpcl_pkg::cmd_t'(req.command))
			fpcl_pkg::CMD_START: begin
				if ((cur.phase == fpcl_pkg::PH_IDLE) || finished) begin
					nxt.pins = fpcl_pkg::PINS_START;
					nxt.bus = fpcl_pkg::BUS_IDLE;
					nxt.poll = '0;
					nxt.phase = fpcl_pkg::PH_RESET_LOW;
				end
			end
			fpcl_pkg::CMD_BYTE: begin
				if (cur.phase == fpcl_pkg::PH_LOADING) begin
					low_st.bus = fpcl_pkg::flip_byte(req.stream_byte);
					nxt.bus = low_st.bus;
					two = 1'b1;
				end
			end
			fpcl_pkg::CMD_END: begin
				if (cur.phase == fpcl_pkg::PH_LOADING) begin
					nxt.poll = '0;
					nxt.phase = fpcl_pkg::PH_WAIT_DONE;
				end
			end
			fpcl_pkg::CMD_TICK: begin
				if (low_wait || (cur.phase == fpcl_pkg::PH_RESET_HIGH)) begin
					// INIT_B polls after PROG_B assert and after its release.
					if (cur.poll >= wait_limit) begin
						nxt.phase = fpcl_pkg::PH_RESET_TIMEOUT;
					end else if (low_wait ? !req.init_pin : req.init_pin) begin
						nxt.poll = '0;
						if (low_wait) begin
							nxt.pins[fpcl_pkg::PIN_PROG] = 1'b1;
							nxt.phase = fpcl_pkg::PH_RESET_HIGH;
						end else begin
							nxt.pins[fpcl_pkg::PIN_SELECT] = 1'b0;
							nxt.pins[fpcl_pkg::PIN_WRITE] = 1'b0;
							nxt.phase = fpcl_pkg::PH_LOADING;
						end
					end else begin
						nxt.poll = poll_inc;
						if (poll_inc >= wait_limit) begin
							nxt.phase = fpcl_pkg::PH_RESET_TIMEOUT;
						end
					end
				end else if (cur.phase == fpcl_pkg::PH_WAIT_DONE) begin
					// Pulse CCLK until DONE rises; INIT_B low means a CRC error.
					if (cur.poll >= done_lim) begin
						nxt.phase = fpcl_pkg::PH_DONE_TIMEOUT;
					end else begin
						nxt.pins[fpcl_pkg::PIN_CLOCK] = 1'b0;
						if (req.done_pin) begin
							nxt.poll = '0;
							if (cfg.trailing_pulses == '0) begin
								nxt.pins[fpcl_pkg::PIN_SELECT] = 1'b1;
								nxt.pins[fpcl_pkg::PIN_WRITE] = 1'b1;
								nxt.phase = fpcl_pkg::PH_CONFIGURED;
							end else begin
								nxt.phase = fpcl_pkg::PH_TRAILING;
							end
						end else if (!req.init_pin) begin
							nxt.phase = fpcl_pkg::PH_CRC_ERROR;
						end else begin
							two = 1'b1;
							nxt.pins[fpcl_pkg::PIN_CLOCK] = 1'b1;
							nxt.poll = poll_inc;
							if (poll_inc >= done_lim) begin
								nxt.phase = fpcl_pkg::PH_DONE_TIMEOUT;
							end
						end
					end
				end else if (cur.phase == fpcl_pkg::PH_TRAILING) begin
					// Extra pulses after DONE, then release the port.
					two = 1'b1;
					nxt.pins[fpcl_pkg::PIN_CLOCK] = 1'b1;
					nxt.poll = poll_inc;
					if (poll_inc >= trail_lim) begin
						nxt.poll = '0;
						nxt.pins[fpcl_pkg::PIN_SELECT] = 1'b1;
						nxt.pins[fpcl_pkg::PIN_WRITE] = 1'b1;
						nxt.phase = fpcl_pkg::PH_CONFIGURED;
					end
				end
			end
			default: begin
				nxt = cur;
			end
		endcase

		mid = fpcl_pkg::make_rsp(low_st, 1'b0);
		second = fpcl_pkg::make_rsp(nxt, 1'b1);
		first = two ? mid : second;
	end

endmodule

`default_nettype wire

>>> hw/rtl/fpcl_obuf.sv
`timescale 1ns / 1ps
`default_nettype none

module fpcl_obuf (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic load,
	input wire logic two,
	input wire fpcl_pkg::rsp_t first,
	input wire fpcl_pkg::rsp_t second,
	output logic ready,
	output logic hold_busy,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output fpcl_pkg::rsp_t rsp
);

	logic out_valid_q;
	logic hold_valid_q;
	fpcl_pkg::rsp_t out_q;
	fpcl_pkg::rsp_t hold_q;
	logic out_adv;

	// The output slot frees when empty or when its item is taken.
	assign out_adv = !out_valid_q || !rsp_stall;
	assign ready = !hold_valid_q && out_adv;

	// Valid flags for the output slot and the second-item holding slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			hold_valid_q <= two;
		end else if (hold_valid_q && out_adv) begin
			out_valid_q <= 1'b1;
			hold_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload moves from the step logic or from the holding slot.
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= first;
			hold_q <= second;
		end else if (hold_valid_q && out_adv) begin
			out_q <= hold_q;
		end
	end

	assign hold_busy = hold_valid_q;
	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/fpga_parallel_config_loader_top.sv
// Path: an accepted item is held in the input register, then its first result is registered into the output slot.
// Throughput: one item per cycle for single-result commands while rsp_stall is low; bytes
// and clock pulses emit CCLK low then high through the single output port, so the next item waits for the holding slot.
// Reset: arst_n clears the phase to idle, pins to all ones, bus to 0xFF, the poll
// count to zero, the limits to their defaults and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none
`include "fpga_parallel_config_loader_top_macros.svh"

module fpga_parallel_config_loader_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic [fpcl_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [fpcl_pkg::CFG_DATA_W-1:0] cfg_data,
	input wire logic req_valid,
	output logic req_stall,
	input wire fpcl_pkg::req_t req,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output fpcl_pkg::rsp_t rsp
);

	fpcl_pkg::cfg_t cfg;
	fpcl_pkg::req_t req_s1;
	logic valid_s1;
	fpcl_pkg::state_t state_q;
	fpcl_pkg::state_t state_nxt;
	fpcl_pkg::rsp_t first;
	fpcl_pkg::rsp_t second;
	logic two;
	logic obuf_ready;
	logic hold_busy;
	logic proc;
	logic accept;

	fpcl_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	// The held item is worked on once the output side can take its results.
	assign proc = valid_s1 && obuf_ready;
	assign req_stall = valid_s1 && !proc;
	assign accept = req_valid && !req_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	fpcl_step u_step (
		.cur(state_q),
		.req(req_s1),
		.cfg(cfg),
		.nxt(state_nxt),
		.first(first),
		.second(second),
		.two(two)
	);

	// Port state: phase, poll count, pin levels and bus value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= fpcl_pkg::PH_IDLE;
			state_q.poll <= '0;
			state_q.pins <= fpcl_pkg::PINS_RESET;
			state_q.bus <= fpcl_pkg::BUS_IDLE;
		end else if (proc) begin
			state_q <= state_nxt;
		end
	end

	fpcl_obuf u_obuf (
		.clk(clk),
		.arst_n(arst_n),
		.load(proc),
		.two(two),
		.first(first),
		.second(second),
		.ready(obuf_ready),
		.hold_busy(hold_busy),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// A pending second item always sits behind a valid output item.
	`FPCL_ASSERT_SAME(a_hold_behind_out, clk, arst_n, hold_busy, rsp_valid)
	// A byte or clock pulse item leaves its high half waiting in the holding slot.
	`FPCL_ASSERT_NEXT(a_pulse_holds, clk, arst_n, proc && two, hold_busy)
	// PROG_B stays low for the whole INIT_B low wait.
	`FPCL_ASSERT_SAME(a_prog_low, clk, arst_n,
		state_q.phase == fpcl_pkg::PH_RESET_LOW, !state_q.pins[fpcl_pkg::PIN_PROG])
	// While loading the FPGA is selected for write and out of reset.
	`FPCL_ASSERT_SAME(a_load_pins, clk, arst_n, state_q.phase == fpcl_pkg::PH_LOADING,
		!state_q.pins[fpcl_pkg::PIN_SELECT] && !state_q.pins[fpcl_pkg::PIN_WRITE] &&
		state_q.pins[fpcl_pkg::PIN_PROG])

endmodule

`default_nettype wire
